>>> sv/urxq_pkg.sv
// Shared types and constants for the serial receive ring buffer.
package urxq_pkg;

   // Reset value of the quiet-time counter and of its reload register
   localparam logic [7:0] QUIET_RESET = 8'd3;

   typedef enum logic [1:0] {
      ACT_BYTE  = 2'd0,
      ACT_TICK  = 2'd1,
      ACT_READ  = 2'd2,
      ACT_CLEAR = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_BUSY  = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_RESP = 1'b1
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic       load;
      logic       push;
      logic       tick;
      logic       pop;
      logic       clear;
      status_type code;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic quiet_zero;
      logic empty;
   } sts_type;

endpackage

>>> sv/urxq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module urxq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/urxq_ctrl.sv
// Controller: handshake state machine and action decode for the ring buffer.
module urxq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_action,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  urxq_pkg::sts_type dp_sts,
   output urxq_pkg::cmd_type cmd
);

   urxq_pkg::state_type  state_ff;
   urxq_pkg::state_type  state_in;
   urxq_pkg::action_type action;
   logic                 accept;

   assign action = urxq_pkg::action_type'(req_action);
   assign accept = req_valid && !req_stall;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= urxq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state, handshake and datapath commands
   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      cmd       = '0;
      cmd.code  = urxq_pkg::ST_OK;
      unique case (state_ff)
         urxq_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = urxq_pkg::S_RESP;
               unique case (action)
                  urxq_pkg::ACT_BYTE:  cmd.push = 1'b1;
                  urxq_pkg::ACT_TICK:  cmd.tick = 1'b1;
                  urxq_pkg::ACT_READ: begin
                     // refuse while quiet, report empty, else pop
                     if (!dp_sts.quiet_zero) begin
                        cmd.code = urxq_pkg::ST_BUSY;
                     end else if (dp_sts.empty) begin
                        cmd.code = urxq_pkg::ST_EMPTY;
                     end else begin
                        cmd.pop = 1'b1;
                     end
                  end
                  urxq_pkg::ACT_CLEAR: cmd.clear = 1'b1;
                  default:             cmd.clear = 1'b1;
               endcase
            end
         end
         urxq_pkg::S_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = urxq_pkg::S_IDLE;
            end
         end
         default: state_in = urxq_pkg::S_IDLE;
      endcase
   end

   // Every accepted item yields a result in the following cycle
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted item did not produce a result");

   // No new item is taken while a result is pending
   a_no_accept_in_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input accepted while a result is pending");

   // A pop only happens on a quiet, non-empty ring
   a_pop_legal: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> (dp_sts.quiet_zero && !dp_sts.empty))
      else $error("pop issued on a busy or empty ring");

   // A taken result is not shown twice
   a_rsp_once: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |=> !rsp_valid)
      else $error("result repeated after transfer");

endmodule

>>> sv/urxq_dp.sv
// Datapath: ring indices, full flag, quiet counter, store and result registers.
module urxq_dp #(
   parameter int DEPTH = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  urxq_pkg::cmd_type cmd,
   output urxq_pkg::sts_type dp_sts,
   input  logic [7:0]        req_rx_byte,
   input  logic              csr_wr_en,
   input  logic [7:0]        csr_wr_data,
   output logic [7:0]        rsp_read_byte,
   output logic [1:0]        rsp_status,
   output logic              rsp_full_flag
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

   logic [IDX_W-1:0]     wr_idx_ff;
   logic [IDX_W-1:0]     wr_idx_in;
   logic [IDX_W-1:0]     rd_idx_ff;
   logic [IDX_W-1:0]     rd_idx_in;
   logic                 full_ff;
   logic                 full_in;
   logic [7:0]           quiet_ff;
   logic [7:0]           quiet_in;
   logic [7:0]           reload_ff;
   urxq_pkg::status_type status_ff;
   logic                 sel_ff;
   logic [IDX_W-1:0]     wr_next;
   logic [IDX_W-1:0]     rd_next;
   logic [7:0]           ram_rd_data;

   // Wrap the indices at the ring's last entry
   assign wr_next = (wr_idx_ff == LAST_IDX) ? '0 : wr_idx_ff + 1'b1;
   assign rd_next = (rd_idx_ff == LAST_IDX) ? '0 : rd_idx_ff + 1'b1;

   // Next index, flag and counter values
   always_comb begin
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      full_in   = full_ff;
      quiet_in  = quiet_ff;
      if (cmd.push) begin
         quiet_in  = reload_ff;
         wr_idx_in = wr_next;
         // drop the oldest byte when the writer catches the reader
         if (wr_next == rd_idx_ff) begin
            rd_idx_in = rd_next;
            full_in   = 1'b1;
         end
      end
      if (cmd.tick && quiet_ff != 8'd0) begin
         quiet_in = quiet_ff - 8'd1;
      end
      if (cmd.pop) begin
         rd_idx_in = rd_next;
         full_in   = 1'b0;
      end
      if (cmd.clear) begin
         wr_idx_in = '0;
         rd_idx_in = '0;
         full_in   = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         full_ff   <= 1'b0;
         quiet_ff  <= urxq_pkg::QUIET_RESET;
         reload_ff <= urxq_pkg::QUIET_RESET;
         status_ff <= urxq_pkg::ST_OK;
         sel_ff    <= 1'b0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         full_ff   <= full_in;
         quiet_ff  <= quiet_in;
         if (csr_wr_en) begin
            reload_ff <= csr_wr_data;
         end
         if (cmd.load) begin
            status_ff <= cmd.code;
            sel_ff    <= cmd.pop;
         end
      end
   end

   // Byte store
   urxq_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (wr_idx_ff),
      .wr_data (req_rx_byte),
      .rd_en   (cmd.pop),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rd_data)
   );

   assign dp_sts.quiet_zero = (quiet_ff == 8'd0);
   assign dp_sts.empty      = (rd_idx_ff == wr_idx_ff) && !full_ff;

   // Result fields hold while the result waits
   assign rsp_read_byte = sel_ff ? ram_rd_data : 8'd0;
   assign rsp_status    = status_ff;
   assign rsp_full_flag = full_ff;

endmodule

>>> sv/uart_rx_ring_fifo_with_quiet_gate.sv
// Top level of the serial receive ring buffer with a quiet-time read gate.
//
// Input channel (req_valid / req_stall) carries one action per transfer:
// received byte, time tick, read one byte or clear. Each transfer yields
// exactly one result on the output channel (rsp_valid / rsp_stall): the
// byte read (else 0), a status code (ok, empty, busy) and the full flag.
// A received byte reloads the quiet counter; reads report busy until
// enough ticks have counted it down to zero. When the ring overflows the
// oldest byte is dropped and the full flag is set.
// The result is offered in the cycle after the input transfer. No new
// item is taken while a result is pending: there is a single result
// register, and the byte store has a registered read port.
// While a result waits under rsp_stall, req_stall stays high and all
// state holds. Reset (synchronous, active high) empties the ring, clears
// the full flag and sets counter and reload register to 3; store contents
// are not cleared and need no clearing pass. csr_wr_en writes the quiet
// reload value from csr_wr_data; write it only while the block is idle.
module uart_rx_ring_fifo_with_quiet_gate #(
   parameter int DEPTH = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_action,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_byte,
   output logic [1:0] rsp_status,
   output logic       rsp_full_flag,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   urxq_pkg::cmd_type cmd;
   urxq_pkg::sts_type dp_sts;

   // Handshake and decode
   urxq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_action),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .dp_sts     (dp_sts),
      .cmd        (cmd)
   );

   // Ring state and store
   urxq_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .dp_sts        (dp_sts),
      .req_rx_byte   (req_rx_byte),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .rsp_read_byte (rsp_read_byte),
      .rsp_status    (rsp_status),
      .rsp_full_flag (rsp_full_flag)
   );

endmodule

>>> bench/tb.sv
// Testbench for the serial receive ring buffer with a quiet-time read gate.
`timescale 1ns / 1ps

module tb;

   localparam int RING_DEPTH  = 256;
   localparam int IDLE_LIMIT  = 400;
   localparam int PHASE_ITEMS = 40;
   localparam int NROWS       = 26;

   typedef struct packed {
      logic [7:0]           read_byte;
      urxq_pkg::status_type status;
      logic                 full_flag;
   } ring_result_type;

   typedef enum logic { ROW_ITEM = 1'b0, ROW_CFG = 1'b1 } row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      urxq_pkg::action_type act;
      logic [7:0]           data;
      logic                 typed;
      logic [7:0]           exp_byte;
      urxq_pkg::status_type exp_status;
      logic                 exp_full;
   } dir_row_type;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic [1:0] req_action  = urxq_pkg::ACT_TICK;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_stall   = 1'b0;
   logic       csr_wr_en   = 1'b0;
   logic [7:0] csr_wr_data = 8'h00;
   logic       req_stall;
   logic       rsp_valid;
   logic [7:0] rsp_read_byte;
   logic [1:0] rsp_status;
   logic       rsp_full_flag;

   // Ring model held by the bench
   logic [7:0] ring_mem [RING_DEPTH];
   logic [7:0] wr_ptr       = 8'd0;
   logic [7:0] rd_ptr       = 8'd0;
   logic       ring_full    = 1'b0;
   logic [7:0] quiet_left   = urxq_pkg::QUIET_RESET;
   logic [7:0] quiet_reload = urxq_pkg::QUIET_RESET;

   ring_result_type pending_results [$];
   int errors      = 0;
   int items_sent  = 0;
   int idle_cycles = 0;
   bit calm        = 1'b0;

   // Directed table: typed rows carry their own expectation
   dir_row_type dir_rows [NROWS] = '{
      '{ROW_ITEM, urxq_pkg::ACT_READ,  8'h00, 1'b1, 8'h00, urxq_pkg::ST_BUSY,  1'b0},
      '{ROW_ITEM, urxq_pkg::ACT_TICK,  8'h00, 1'b1, 8'h00, urxq_pkg::ST_OK,    1'b0},
      '{ROW_ITEM, urxq_pkg::ACT_TICK,  8'h00, 1'b1, 8'h00, urxq_pkg::ST_OK,    1'b0},
      '{ROW_ITEM, urxq_pkg::ACT_READ,  8'h00, 1'b1, 8'h00, urxq_pkg::ST_BUSY,  1'b0},
      '{ROW_ITEM, urxq_pkg::ACT_TICK,  8'h00, 1'b1, 8'h00, urxq_pkg::ST_OK,    1'b0},
      '{ROW_ITEM, urxq_pkg::ACT_TICK,  8'h00, 1'b1, 8'h00, urxq_pkg::ST_OK,    1'b0},
      '{ROW_ITEM, urxq_pkg::ACT_READ,  8'h00, 1'b1, 8'h00, urxq_pkg::ST_EMPTY, 1'b0},
      '{ROW_ITEM, urxq_pkg::ACT_BYTE,  8'h00, 1'b1, 8'h00, urxq_pkg::ST_OK,    1'b0},
      '{ROW_ITEM, urxq_pkg::ACT_BYTE,  8'hFF, 1'b1, 8'h00, urxq_pkg::ST_OK,    1'b0},
      '{ROW_ITEM, urxq_pkg::ACT_READ,  8'h00, 1'b1, 8'h00, urxq_pkg::ST_BUSY,  1'b0},
      '{ROW_ITEM, urxq_pkg::ACT_TICK,  8'h00, 1'b1, 8'h00, urxq_pkg::ST_OK,    1'b0},
      '{ROW_ITEM, urxq_pkg::ACT_TICK,  8'h00, 1'b1, 8'h00, urxq_pkg::ST_OK,    1'b0},
      '{ROW_ITEM, urxq_pkg::ACT_TICK,  8'h00, 1'b1, 8'h00, urxq_pkg::ST_OK,    1'b0},
      '{ROW_ITEM, urxq_pkg::ACT_READ,  8'h00, 1'b0, 8'h00, urxq_pkg::ST_OK,    1'b0},
      '{ROW_ITEM, urxq_pkg::ACT_READ,  8'h00, 1'b0, 8'h00, urxq_pkg::ST_OK,    1'b0},
      '{ROW_ITEM, urxq_pkg::ACT_READ,  8'h00, 1'b1, 8'h00, urxq_pkg::ST_EMPTY, 1'b0},
      '{ROW_ITEM, urxq_pkg::ACT_BYTE,  8'hA5, 1'b0, 8'h00, urxq_pkg::ST_OK,    1'b0},
      '{ROW_ITEM, urxq_pkg::ACT_CLEAR, 8'h00, 1'b1, 8'h00, urxq_pkg::ST_OK,    1'b0},
      '{ROW_ITEM, urxq_pkg::ACT_READ,  8'h00, 1'b0, 8'h00, urxq_pkg::ST_OK,    1'b0},
      '{ROW_ITEM, urxq_pkg::ACT_TICK,  8'h00, 1'b0, 8'h00, urxq_pkg::ST_OK,    1'b0},
      '{ROW_ITEM, urxq_pkg::ACT_TICK,  8'h00, 1'b0, 8'h00, urxq_pkg::ST_OK,    1'b0},
      '{ROW_ITEM, urxq_pkg::ACT_TICK,  8'h00, 1'b0, 8'h00, urxq_pkg::ST_OK,    1'b0},
      '{ROW_ITEM, urxq_pkg::ACT_READ,  8'h00, 1'b0, 8'h00, urxq_pkg::ST_OK,    1'b0},
      '{ROW_CFG,  urxq_pkg::ACT_TICK,  8'h00, 1'b0, 8'h00, urxq_pkg::ST_OK,    1'b0},
      '{ROW_ITEM, urxq_pkg::ACT_BYTE,  8'h5A, 1'b0, 8'h00, urxq_pkg::ST_OK,    1'b0},
      '{ROW_ITEM, urxq_pkg::ACT_READ,  8'h00, 1'b0, 8'h00, urxq_pkg::ST_OK,    1'b0}
   };

   uart_rx_ring_fifo_with_quiet_gate dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_rx_byte   (req_rx_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_read_byte (rsp_read_byte),
      .rsp_status    (rsp_status),
      .rsp_full_flag (rsp_full_flag),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Advance the ring model by one action and return the result it owes
   function automatic ring_result_type predict_ring(urxq_pkg::action_type a,
                                                    logic [7:0] d);
      ring_result_type r;
      r = '{read_byte: 8'h00, status: urxq_pkg::ST_OK, full_flag: 1'b0};
      case (a)
         urxq_pkg::ACT_BYTE: begin
            quiet_left       = quiet_reload;
            ring_mem[wr_ptr] = d;
            wr_ptr           = wr_ptr + 8'd1;
            // drop the oldest byte when the writer laps the reader
            if (wr_ptr == rd_ptr) begin
               rd_ptr    = rd_ptr + 8'd1;
               ring_full = 1'b1;
            end
         end
         urxq_pkg::ACT_TICK: begin
            if (quiet_left != 8'd0) quiet_left = quiet_left - 8'd1;
         end
         urxq_pkg::ACT_READ: begin
            if (quiet_left != 8'd0) begin
               r.status = urxq_pkg::ST_BUSY;
            end else if (rd_ptr == wr_ptr && !ring_full) begin
               r.status = urxq_pkg::ST_EMPTY;
            end else begin
               r.read_byte = ring_mem[rd_ptr];
               rd_ptr      = rd_ptr + 8'd1;
               ring_full   = 1'b0;
            end
         end
         default: begin
            wr_ptr    = 8'd0;
            rd_ptr    = 8'd0;
            ring_full = 1'b0;
         end
      endcase
      r.full_flag = ring_full;
      return r;
   endfunction

   function automatic int draw_wait();
      if (calm || $urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, 16);
   endfunction

   // Offer one item, hold it until the transfer, then log its expectation
   task automatic drive_item(urxq_pkg::action_type a, logic [7:0] d, bit typed,
                             ring_result_type typed_res);
      int gap;
      ring_result_type res;
      gap = draw_wait();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   = 1'b1;
      req_action  = a;
      req_rx_byte = d;
      do @(posedge clock); while (req_stall);
      res = predict_ring(a, d);
      if (typed) res = typed_res;
      pending_results.push_back(res);
      items_sent++;
   endtask

   task automatic send(urxq_pkg::action_type a, logic [7:0] d);
      drive_item(a, d, 1'b0, '0);
   endtask

   // Drop valid and let the ring drain before anything else happens
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Write the quiet reload register while the block is idle
   task automatic set_quiet(logic [7:0] v);
      drain();
      repeat (3) @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = v;
      @(negedge clock);
      csr_wr_en    = 1'b0;
      quiet_reload = v;
   endtask

   // One random sequence: mostly bytes, ticks to quiet, then reads
   task automatic run_sequence(bit long_burst);
      int nb;
      int nt;
      int nr;
      calm = ($urandom_range(0, 4) == 0);
      if (!long_burst && $urandom_range(0, 4) == 0) begin
         // noise: any action in any order
         repeat ($urandom_range(1, 12))
            send(urxq_pkg::action_type'($urandom_range(0, 3)),
                 8'($urandom_range(0, 255)));
      end else begin
         nb = long_burst ? $urandom_range(250, 270) : $urandom_range(1, 10);
         repeat (nb) begin
            send(urxq_pkg::ACT_BYTE, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 7) == 0)
               send(urxq_pkg::ACT_READ, 8'($urandom_range(0, 255)));
         end
         nt = int'(quiet_reload) + $urandom_range(0, 2);
         // a short count leaves the gate closed
         if ($urandom_range(0, 4) == 0 && quiet_reload != 8'd0) nt = int'(quiet_reload) - 1;
         repeat (nt) send(urxq_pkg::ACT_TICK, 8'($urandom_range(0, 255)));
         nr = $urandom_range(1, nb + 2);
         repeat (nr) send(urxq_pkg::ACT_READ, 8'($urandom_range(0, 255)));
         if ($urandom_range(0, 5) == 0) send(urxq_pkg::ACT_CLEAR, 8'($urandom_range(0, 255)));
      end
   endtask

   // Check each result transfer against the oldest expectation
   always @(posedge clock) begin
      ring_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: read_byte %0h status %0d full_flag %0b",
                   rsp_read_byte, rsp_status, rsp_full_flag);
            errors++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_read_byte !== e.read_byte) begin
               $error("read_byte: expected %0h, got %0h", e.read_byte, rsp_read_byte);
               errors++;
            end
            if (rsp_status !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp_status);
               errors++;
            end
            if (rsp_full_flag !== e.full_flag) begin
               $error("full_flag: expected %0b, got %0b", e.full_flag, rsp_full_flag);
               errors++;
            end
         end
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // Result side: stall for a random number of cycles before each transfer
   initial begin
      int n;
      while (reset) @(negedge clock);
      forever begin
         n = draw_wait();
         if (n > 0) begin
            rsp_stall = 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin
      ring_result_type typed_res;
      logic [7:0] phase_quiet [6];
      int start;
      phase_quiet = '{8'd0, 8'd1, 8'd255, 8'($urandom_range(4, 254)), 8'd3, 8'd2};

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table
      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CFG) begin
            set_quiet(dir_rows[i].data);
         end else begin
            typed_res = '{read_byte: dir_rows[i].exp_byte,
                          status:    dir_rows[i].exp_status,
                          full_flag: dir_rows[i].exp_full};
            drive_item(dir_rows[i].act, dir_rows[i].data, dir_rows[i].typed, typed_res);
         end
      end

      // Random phases, one reload setting each; the first opens with a long byte burst
      foreach (phase_quiet[p]) begin
         set_quiet(phase_quiet[p]);
         start = items_sent;
         if (p == 0) run_sequence(1'b1);
         while (items_sent - start < PHASE_ITEMS) run_sequence(1'b0);
      end

      drain();
      repeat (4) @(posedge clock);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> files.f
sv/urxq_pkg.sv
sv/urxq_ram.sv
sv/urxq_ctrl.sv
sv/urxq_dp.sv
sv/uart_rx_ring_fifo_with_quiet_gate.sv
bench/tb.sv
